// ===== rtl/hri_pkg.sv =====
package hri_pkg;

  // field widths
  localparam int unsigned IDX_W      = 31;
  localparam int unsigned RADIX_W    = 16;
  localparam int unsigned FRAC_OUT_W = 32;
  localparam int unsigned IN_DATA_W  = 48;

  // den stays below radix * 2^31, so 47 bits hold it
  localparam int unsigned DEN_W = IDX_W + RADIX_W;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned PROD_W = DEN_W + RADIX_W;

  localparam int unsigned FRAC_BITS_DEF = 32;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_MULR  = 6'b000100,
    ST_MULD  = 6'b001000,
    ST_FRAC  = 6'b010000,
    ST_DONE  = 6'b100000
  } hri_state_t;

  // result of one restoring division step
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             qbit;
  } hri_step_t;

endpackage

// ===== rtl/hri_divstep.sv =====
module hri_divstep (
  input  logic [hri_pkg::REM_W-1:0] rem,
  input  logic                      shift_in,
  input  logic [hri_pkg::REM_W-1:0] divisor,
  output hri_pkg::hri_step_t        step
);
  import hri_pkg::*;

  logic [REM_W-1:0] shl;
  logic [REM_W-1:0] diff;
  logic             ge;

  // shift one bit in, trial subtract, restore on borrow
  always_comb begin
    shl       = {rem[REM_W-2:0], shift_in};
    diff      = shl - divisor;
    ge        = (shl >= divisor);
    step.qbit = ge;
    step.rem  = ge ? diff : shl;
  end

endmodule

// ===== rtl/halton_radical_inverse.sv =====
// channel | dir | ports                         | payload
// in      | in  | in_tvalid/in_tready/in_tdata  | sample_index, radix
// out     | out | out_tvalid/out_tready/...     | fraction (tdata), radix_error (tuser)
//
// one item at a time: in_tready is high only while the block is idle
// an index is worked one base-radix digit at a time: the single shared compare/subtract
// step unit divides it by the radix (31 steps per digit, FRAC_BITS steps for the final
// quotient), and one multiplier step each updates rev and den
// a radix below 2 or a zero index gives its result in the cycle after accept
// reset (rst_n low, synchronous) returns the sequencer to idle, no result pending
// a result waits in the output register until out_tready; no input is taken meanwhile
module halton_radical_inverse #(
  parameter int unsigned FRAC_BITS = hri_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hri_pkg::IN_DATA_W-1:0]   in_tdata,   // [30:0] sample_index, [46:31] radix
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hri_pkg::FRAC_OUT_W-1:0]  out_tdata,  // [31:0] fraction
  output logic [0:0]                      out_tuser   // [0] radix_error
);
  import hri_pkg::*;

  localparam int unsigned STEPS_MAX = (FRAC_BITS > IDX_W) ? FRAC_BITS : IDX_W;
  localparam int unsigned CNT_W     = $clog2(STEPS_MAX);

  hri_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     rev_r, rev_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic                 err_r, err_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [IDX_W-1:0]     in_idx;
  logic [RADIX_W-1:0]   in_radix;
  logic                 in_acc;

  logic                 unit_in;
  logic [REM_W-1:0]     unit_dvs;
  hri_step_t            unit_out;

  logic [DEN_W-1:0]     mul_a;
  logic [PROD_W-1:0]    prod;
  logic [FRAC_BITS+FRAC_OUT_W-1:0] q_wide;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_radix = in_tdata[IDX_W+RADIX_W-1:IDX_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // shared step unit: digit division by radix, then fraction division by den
  always_comb begin
    if (state_r == ST_DIV) begin
      unit_in  = idx_r[IDX_W-1];
      unit_dvs = {{(REM_W-RADIX_W){1'b0}}, radix_r};
    end else begin
      unit_in  = 1'b0;
      unit_dvs = {1'b0, den_r};
    end
  end

  hri_divstep u_step (
    .rem      (rem_r),
    .shift_in (unit_in),
    .divisor  (unit_dvs),
    .step     (unit_out)
  );

  // one multiplier, shared between rev and den updates
  assign mul_a = (state_r == ST_MULR) ? rev_r : den_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'(radix_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    radix_nxt = radix_r;
    rem_nxt   = rem_r;
    rev_nxt   = rev_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt   = in_idx;
          radix_nxt = in_radix;
          rem_nxt   = '0;
          rev_nxt   = '0;
          den_nxt   = DEN_W'(1);
          q_nxt     = '0;
          cnt_nxt   = '0;
          err_nxt   = (in_radix < RADIX_W'(2));
          if ((in_radix < RADIX_W'(2)) || (in_idx == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = unit_out.rem;
        idx_nxt = {idx_r[IDX_W-2:0], unit_out.qbit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          state_nxt = ST_MULR;
        end
      end
      ST_MULR: begin
        // digit is the remainder, below radix
        rev_nxt   = prod[DEN_W-1:0] + DEN_W'(rem_r[RADIX_W-1:0]);
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        den_nxt = prod[DEN_W-1:0];
        cnt_nxt = '0;
        if (idx_r == '0) begin
          rem_nxt   = {1'b0, rev_r};
          state_nxt = ST_FRAC;
        end else begin
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_FRAC: begin
        rem_nxt = unit_out.rem;
        q_nxt   = {q_r[FRAC_BITS-2:0], unit_out.qbit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    radix_r <= radix_nxt;
    rem_r   <= rem_nxt;
    rev_r   <= rev_nxt;
    den_r   <= den_nxt;
    q_r     <= q_nxt;
    err_r   <= err_nxt;
    cnt_r   <= cnt_nxt;
  end

  // result carries the low 32 bits of the quotient
  assign q_wide     = {{FRAC_OUT_W{1'b0}}, q_r};
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = q_wide[FRAC_OUT_W-1:0];
  assign out_tuser  = err_r;

  // never both sides open at once
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // error result has a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("radix error with nonzero fraction");

  // bad radix answers on the next cycle with the flag
  a_err_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[IDX_W+RADIX_W-1:IDX_W+1] == '0))
    |=> (out_tvalid && out_tuser[0]))
    else $error("radix below two not flagged");

  // digit remainder stays below the radix
  a_digit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {{(REM_W-RADIX_W){1'b0}}, radix_r}))
    else $error("digit remainder out of range");

endmodule
